// ===== src/bzf_pkg.sv =====
// Shared types and constants of the cubic curve flattener.
// No dependencies; every other file of the block refers to this package.
package bzf_pkg;

  // Coordinate format at the ports and inside the block.
  localparam int unsigned CoordW    = 24;
  localparam int unsigned GuardBits = 6;
  localparam int unsigned IntW      = CoordW + GuardBits;
  localparam int unsigned TolW      = 16;

  // Subdivision depth limit and the width of level and stack counters.
  localparam int unsigned MaxDepth  = 6;
  localparam int unsigned LvlW      = 3;

  localparam logic [TolW-1:0] TolReset = 16'd64;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [IntW-1:0]   icoord_t;
  typedef logic [LvlW-1:0]          lvl_t;
  typedef logic [TolW-1:0]          tol_t;

  // A curve piece: start, first inner, second inner and end point, x before y.
  typedef icoord_t piece_t [8];

  // Result of one flatness test.
  typedef struct packed {
    logic done;
    logic flat;
  } ft_res_t;

  // Status of the subdivision engine.
  typedef struct packed {
    logic busy;
    lvl_t depth;
  } bk_stat_t;

endpackage

// ===== src/bzf_curve_if.sv =====
// Input channel of the flattener: the four control points of one curve.
// Depends on bzf_pkg for the coordinate type.
interface bzf_curve_if;
  logic            valid;
  logic            ready;
  bzf_pkg::coord_t start_x;
  bzf_pkg::coord_t start_y;
  bzf_pkg::coord_t ctrl1_x;
  bzf_pkg::coord_t ctrl1_y;
  bzf_pkg::coord_t ctrl2_x;
  bzf_pkg::coord_t ctrl2_y;
  bzf_pkg::coord_t end_x;
  bzf_pkg::coord_t end_y;

  modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                end_x, end_y, output ready);
endinterface

// ===== src/bzf_point_if.sv =====
// Output channel of the flattener: one polyline vertex per transaction.
// Depends on bzf_pkg for the coordinate type.
interface bzf_point_if;
  logic            valid;
  logic            ready;
  bzf_pkg::coord_t point_x;
  bzf_pkg::coord_t point_y;
  logic            last_point;
  logic            depth_capped;

  modport source (output valid, point_x, point_y, last_point, depth_capped, input ready);
  modport sink (input valid, point_x, point_y, last_point, depth_capped, output ready);
endinterface

// ===== src/cubic_bezier_adaptive_flattener.sv =====
// Adaptive flattener for one cubic curve: top level with the tolerance register.
// Depends on bzf_pkg, bzf_curve_if, bzf_point_if, bzf_front and bzf_back.
//
// Use: a curve (four control points, signed Q16.8) enters on curve_i as one
// transaction. The block halves it at the parameter midpoint until every piece
// lies within flat_tolerance of its chord and sends the end point of each flat
// piece, in curve order, as one transaction on point_o. The vertex equal to
// the curve end carries last_point. Pieces halved six times are sent anyway
// and carry depth_capped when they fail the test.
// Each flatness test forms its twelve products in turn on the single 33x33
// multiplier, and each vertex is registered before it is sent on point_o.
// One split to full depth needs 127 tests. One curve is worked on at
// a time; a two-entry queue behind curve_i takes further curves meanwhile.
// The user is to write the tolerance through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block itself does not enforce this.
// Reset clears the queue and engine and sets the tolerance to 64.
// A stalled point_o holds its vertex while the engine finishes the next test.
module cubic_bezier_adaptive_flattener (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  bzf_pkg::tol_t cfg_wdata_i,
  bzf_curve_if.sink     curve_i,
  bzf_point_if.source   point_o
);

  bzf_pkg::tol_t     tol_q;
  logic              q_valid, q_pop;
  bzf_pkg::piece_t   q_piece;
  bzf_pkg::bk_stat_t bk_stat;

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= bzf_pkg::TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  bzf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .curve_i   (curve_i),
    .q_valid_o (q_valid),
    .q_piece_o (q_piece),
    .q_pop_i   (q_pop)
  );

  bzf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_piece_i (q_piece),
    .q_pop_o   (q_pop),
    .tol_i     (tol_q),
    .point_o   (point_o),
    .stat_o    (bk_stat)
  );

  // The engine never takes a curve from an empty queue.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("curve taken from empty queue");

  // The pending stack never grows past the depth limit.
  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.depth <= bzf_pkg::LvlW'(bzf_pkg::MaxDepth))
    else $error("pending stack overflow");

  // An idle engine has left no pending halves behind.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bk_stat.busy |-> (bk_stat.depth == '0)) else $error("idle with pending pieces");

  // A curve is taken only by an idle engine and starts with an empty stack.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (bk_stat.busy && (bk_stat.depth == '0)))
    else $error("curve started while busy");

endmodule

// ===== src/bzf_front.sv =====
// Front end: accepts curves, widens them to the internal guard-bit format
// and holds them in a two-entry queue. Depends on bzf_pkg and bzf_curve_if.
module bzf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bzf_curve_if.sink            curve_i,
  output logic                 q_valid_o,
  output bzf_pkg::piece_t      q_piece_o,
  input  logic                 q_pop_i
);

  bzf_pkg::piece_t fifo_q [2];
  bzf_pkg::piece_t wide;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  // Append the guard bits to every coordinate.
  assign wide[0] = $signed({curve_i.start_x, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[1] = $signed({curve_i.start_y, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[2] = $signed({curve_i.ctrl1_x, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[3] = $signed({curve_i.ctrl1_y, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[4] = $signed({curve_i.ctrl2_x, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[5] = $signed({curve_i.ctrl2_y, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[6] = $signed({curve_i.end_x, {bzf_pkg::GuardBits{1'b0}}});
  assign wide[7] = $signed({curve_i.end_y, {bzf_pkg::GuardBits{1'b0}}});

  // Queue handshake.
  assign curve_i.ready = (cnt_q != 2'd2);
  assign push          = curve_i.valid && curve_i.ready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_piece_o     = fifo_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= wide;
    end
  end

endmodule

// ===== src/bzf_flat_test.sv =====
// Flatness test of one curve piece, worked out step by step on one shared
// signed 33x33 multiplier. Depends on bzf_pkg.
module bzf_flat_test (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bzf_pkg::piece_t  piece_i,
  input  bzf_pkg::tol_t    tol_i,
  output bzf_pkg::ft_res_t res_o
);

  // Product sequence; each product is registered and consumed by the next step.
  localparam logic [3:0] StUxBy   = 4'd0;
  localparam logic [3:0] StUyBx   = 4'd1;
  localparam logic [3:0] StVxBy   = 4'd2;
  localparam logic [3:0] StVyBx   = 4'd3;
  localparam logic [3:0] StBxBx   = 4'd4;
  localparam logic [3:0] StByBy   = 4'd5;
  localparam logic [3:0] StTolTol = 4'd6;
  localparam logic [3:0] StSlSl   = 4'd7;
  localparam logic [3:0] StSlSh   = 4'd8;
  localparam logic [3:0] StShSh   = 4'd9;
  localparam logic [3:0] StTlLl   = 4'd10;
  localparam logic [3:0] StTlLh   = 4'd11;
  localparam logic [3:0] StLast   = 4'd12;
  localparam logic [3:0] StCmp    = 4'd13;

  logic                running_q;
  logic [3:0]          step_q;
  logic signed [30:0]  bx_q, by_q, ux_q, uy_q, vx_q, vy_q;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_q;
  logic signed [63:0]  cx_q, cdiff;
  logic [62:0]         s_q, s_d;
  logic [61:0]         len_q, len_d;
  logic [31:0]         tol2_q, tol2_d;
  logic [125:0]        lhs_q, lhs_d;
  logic [93:0]         rhs_q, rhs_d;
  logic [63:0]         cmag;

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      step_q    <= StUxBy;
    end else if (start_i) begin
      running_q <= 1'b1;
      step_q    <= StUxBy;
    end else if (running_q) begin
      if (step_q == StCmp) begin
        running_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      StUxBy:   begin mul_a = 33'(ux_q); mul_b = 33'(by_q); end
      StUyBx:   begin mul_a = 33'(uy_q); mul_b = 33'(bx_q); end
      StVxBy:   begin mul_a = 33'(vx_q); mul_b = 33'(by_q); end
      StVyBx:   begin mul_a = 33'(vy_q); mul_b = 33'(bx_q); end
      StBxBx:   begin mul_a = 33'(bx_q); mul_b = 33'(bx_q); end
      StByBy:   begin mul_a = 33'(by_q); mul_b = 33'(by_q); end
      StTolTol: begin
        mul_a = $signed({17'd0, tol_i});
        mul_b = $signed({17'd0, tol_i});
      end
      StSlSl:   begin
        mul_a = $signed({1'b0, s_q[31:0]});
        mul_b = $signed({1'b0, s_q[31:0]});
      end
      StSlSh:   begin
        mul_a = $signed({1'b0, s_q[31:0]});
        mul_b = $signed({2'b0, s_q[62:32]});
      end
      StShSh:   begin
        mul_a = $signed({2'b0, s_q[62:32]});
        mul_b = $signed({2'b0, s_q[62:32]});
      end
      StTlLl:   begin
        mul_a = $signed({1'b0, tol2_q});
        mul_b = $signed({1'b0, len_q[31:0]});
      end
      StTlLh:   begin
        mul_a = $signed({1'b0, tol2_q});
        mul_b = $signed({3'b0, len_q[61:32]});
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Magnitude of a cross product once its second term arrives.
  assign cdiff = cx_q - 64'(prod_q);
  assign cmag  = cdiff[63] ? 64'(-cdiff) : 64'(cdiff);

  // Accumulation of the previous step's product.
  always_comb begin
    s_d    = s_q;
    len_d  = len_q;
    tol2_d = tol2_q;
    lhs_d  = lhs_q;
    rhs_d  = rhs_q;
    unique case (step_q)
      StVxBy:   s_d    = cmag[62:0];
      StBxBx:   s_d    = s_q + cmag[62:0];
      StByBy:   len_d  = prod_q[61:0];
      StTolTol: len_d  = len_q + prod_q[61:0];
      StSlSl:   tol2_d = prod_q[31:0];
      StSlSh:   lhs_d  = 126'(prod_q[63:0]);
      StShSh:   lhs_d  = lhs_q + (126'(prod_q[63:0]) << 33);
      StTlLl:   lhs_d  = lhs_q + (126'(prod_q[61:0]) << 64);
      StTlLh:   rhs_d  = 94'(prod_q[63:0]);
      StLast:   rhs_d  = rhs_q + (94'(prod_q[61:0]) << 32);
      default:  ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bx_q <= 31'(piece_i[6]) - 31'(piece_i[0]);
      by_q <= 31'(piece_i[7]) - 31'(piece_i[1]);
      ux_q <= 31'(piece_i[2]) - 31'(piece_i[6]);
      uy_q <= 31'(piece_i[3]) - 31'(piece_i[7]);
      vx_q <= 31'(piece_i[4]) - 31'(piece_i[6]);
      vy_q <= 31'(piece_i[5]) - 31'(piece_i[7]);
    end
    prod_q <= mul_a * mul_b;
    if (running_q) begin
      if (step_q == StUyBx || step_q == StVyBx) begin
        cx_q <= 64'(prod_q);
      end
      s_q    <= s_d;
      len_q  <= len_d;
      tol2_q <= tol2_d;
      lhs_q  <= lhs_d;
      rhs_q  <= rhs_d;
    end
  end

  // Squared deviation against tolerance squared times chord length squared.
  assign res_o.done = running_q && (step_q == StCmp);
  assign res_o.flat = (lhs_q <= 126'({rhs_q, 12'd0}));

endmodule

// ===== src/bzf_back.sv =====
// Back end: halves pieces on a pending stack until flat or at the depth limit
// and registers each vertex. Depends on bzf_pkg, bzf_point_if, bzf_flat_test.
module bzf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bzf_pkg::piece_t   q_piece_i,
  output logic              q_pop_o,
  input  bzf_pkg::tol_t     tol_i,
  bzf_point_if.source       point_o,
  output bzf_pkg::bk_stat_t stat_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TEST = 3'b010,
    ST_EMIT = 3'b100
  } bk_state_e;

  localparam bzf_pkg::lvl_t MaxLvl = bzf_pkg::LvlW'(bzf_pkg::MaxDepth);

  bk_state_e         state_q, state_d;
  bzf_pkg::piece_t   cur_q, left_half, right_half;
  bzf_pkg::piece_t   stk_q [bzf_pkg::MaxDepth];
  bzf_pkg::lvl_t     lvl_stk_q [bzf_pkg::MaxDepth];
  bzf_pkg::lvl_t     level_q, top_q, pop_idx;
  logic              start_q;
  logic              capped_q;
  bzf_pkg::ft_res_t  ft_res;
  bzf_pkg::icoord_t  p01 [2], p12 [2], p23 [2], p012 [2], p123 [2], pmid [2];
  logic signed [bzf_pkg::IntW:0] rnd_x, rnd_y;
  logic              out_valid_q, out_free, emit_now, do_emit, do_split;
  bzf_pkg::coord_t   out_x_q, out_y_q;
  logic              out_last_q, out_capped_q;

  function automatic bzf_pkg::icoord_t avg(bzf_pkg::icoord_t a, bzf_pkg::icoord_t b);
    logic signed [bzf_pkg::IntW:0] s;
    s = (bzf_pkg::IntW+1)'(a) + (bzf_pkg::IntW+1)'(b) + (bzf_pkg::IntW+1)'(1);
    return s[bzf_pkg::IntW:1];
  endfunction

  bzf_flat_test u_flat_test (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .piece_i (cur_q),
    .tol_i   (tol_i),
    .res_o   (ft_res)
  );

  // De Casteljau halving at the parameter midpoint, both axes.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      p01[k]  = avg(cur_q[k], cur_q[2+k]);
      p12[k]  = avg(cur_q[2+k], cur_q[4+k]);
      p23[k]  = avg(cur_q[4+k], cur_q[6+k]);
      p012[k] = avg(p01[k], p12[k]);
      p123[k] = avg(p12[k], p23[k]);
      pmid[k] = avg(p012[k], p123[k]);
      left_half[k]    = cur_q[k];
      left_half[2+k]  = p01[k];
      left_half[4+k]  = p012[k];
      left_half[6+k]  = pmid[k];
      right_half[k]   = pmid[k];
      right_half[2+k] = p123[k];
      right_half[4+k] = p23[k];
      right_half[6+k] = cur_q[6+k];
    end
  end

  // Test outcome: emit when flat or when the depth limit is reached.
  assign emit_now = ft_res.flat || (level_q >= MaxLvl) || (top_q >= MaxLvl);
  assign do_split = (state_q == ST_TEST) && ft_res.done && !emit_now;
  assign out_free = !out_valid_q || point_o.ready;
  assign do_emit  = (state_q == ST_EMIT) && out_free;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;
  assign pop_idx  = top_q - 3'd1;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_TEST;
      ST_TEST: if (ft_res.done && emit_now) state_d = ST_EMIT;
      ST_EMIT: if (out_free) state_d = (top_q == '0) ? ST_IDLE : ST_TEST;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      top_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= q_pop_o || do_split || (do_emit && (top_q != '0));
      if (q_pop_o) begin
        level_q <= '0;
        top_q   <= '0;
      end else if (do_split) begin
        level_q <= level_q + 3'd1;
        top_q   <= top_q + 3'd1;
      end else if (do_emit && (top_q != '0)) begin
        level_q <= lvl_stk_q[pop_idx];
        top_q   <= pop_idx;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (point_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Rounding from the guard-bit format back to port precision.
  assign rnd_x = (bzf_pkg::IntW+1)'(cur_q[6])
               + (bzf_pkg::IntW+1)'(1 <<< (bzf_pkg::GuardBits - 1));
  assign rnd_y = (bzf_pkg::IntW+1)'(cur_q[7])
               + (bzf_pkg::IntW+1)'(1 <<< (bzf_pkg::GuardBits - 1));

  // Current piece, pending stack and output payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_piece_i;
    end else if (do_split) begin
      cur_q            <= left_half;
      stk_q[top_q]     <= right_half;
      lvl_stk_q[top_q] <= level_q + 3'd1;
    end else if (do_emit && (top_q != '0)) begin
      cur_q <= stk_q[pop_idx];
    end
    if (ft_res.done) begin
      capped_q <= !ft_res.flat;
    end
    if (do_emit) begin
      out_x_q      <= rnd_x[bzf_pkg::IntW-1:bzf_pkg::GuardBits];
      out_y_q      <= rnd_y[bzf_pkg::IntW-1:bzf_pkg::GuardBits];
      out_last_q   <= (top_q == '0);
      out_capped_q <= capped_q;
    end
  end

  assign point_o.valid        = out_valid_q;
  assign point_o.point_x      = out_x_q;
  assign point_o.point_y      = out_y_q;
  assign point_o.last_point   = out_last_q;
  assign point_o.depth_capped = out_capped_q;

  assign stat_o.busy  = (state_q != ST_IDLE);
  assign stat_o.depth = top_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the adaptive cubic curve flattener.
// Depends on bzf_pkg, bzf_curve_if, bzf_point_if and cubic_bezier_adaptive_flattener.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainWait  = 60;

  typedef struct {
    bzf_pkg::coord_t sx, sy, c1x, c1y, c2x, c2y, ex, ey;
  } curve_t;

  typedef struct {
    bzf_pkg::coord_t x, y;
    bit              last, capped;
  } vertex_t;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  bzf_pkg::tol_t cfg_wdata_i;
  bit   quiet;
  int   errors;
  int   cycles;
  int   curves_sent;
  int   vertices_seen;
  int   capped_seen;

  bzf_curve_if curve_ch ();
  bzf_point_if point_ch ();

  cubic_bezier_adaptive_flattener dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .curve_i    (curve_ch.sink),
    .point_o    (point_ch.source)
  );

  // One line per mismatch, and a count for the final verdict.
  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Predicts the vertices of each accepted curve and checks those that come out.
  class vertex_board;
    vertex_t       pending[$];
    bzf_pkg::tol_t tol;

    function new();
      tol = bzf_pkg::TolReset;
    endfunction

    function automatic bit piece_is_flat(longint p[8]);
      longint bx, by, ux, uy, vx, vy, c1, c2;
      longint unsigned s, len_sq;
      logic [127:0] lhs, rhs, s_w, tol_w, len_w;
      bx = p[6] - p[0];
      by = p[7] - p[1];
      ux = p[2] - p[6];
      uy = p[3] - p[7];
      vx = p[4] - p[6];
      vy = p[5] - p[7];
      c1 = ux * by - uy * bx;
      c2 = vx * by - vy * bx;
      s = (c1 < 0 ? -c1 : c1) + (c2 < 0 ? -c2 : c2);
      len_sq = bx * bx + by * by;
      s_w = s;
      tol_w = tol;
      len_w = len_sq;
      lhs = s_w * s_w;
      rhs = ((tol_w * tol_w) * len_w) << 12;
      return lhs <= rhs;
    endfunction

    // Halves the curve depth first, keeping pending second halves on a stack.
    function automatic void note_curve(curve_t c);
      longint cur[8], q[8];
      longint held[bzf_pkg::MaxDepth][8];
      int held_lvl[bzf_pkg::MaxDepth];
      int level, top, k;
      bit flat;
      longint p01, p12, p23, p012, p123, mid;
      vertex_t v;
      cur[0] = c.sx;  cur[1] = c.sy;  cur[2] = c.c1x; cur[3] = c.c1y;
      cur[4] = c.c2x; cur[5] = c.c2y; cur[6] = c.ex;  cur[7] = c.ey;
      for (k = 0; k < 8; k++) cur[k] = cur[k] <<< bzf_pkg::GuardBits;
      level = 0;
      top = 0;
      forever begin
        flat = piece_is_flat(cur);
        if (flat || level >= bzf_pkg::MaxDepth || top >= bzf_pkg::MaxDepth) begin
          v.x = bzf_pkg::coord_t'((cur[6] + 32) >>> bzf_pkg::GuardBits);
          v.y = bzf_pkg::coord_t'((cur[7] + 32) >>> bzf_pkg::GuardBits);
          v.last = (top == 0);
          v.capped = !flat;
          pending.insert(pending.size(), v);
          if (top == 0) break;
          top--;
          cur = held[top];
          level = held_lvl[top];
        end else begin
          for (k = 0; k < 2; k++) begin
            p01  = (cur[k] + cur[2+k] + 1) >>> 1;
            p12  = (cur[2+k] + cur[4+k] + 1) >>> 1;
            p23  = (cur[4+k] + cur[6+k] + 1) >>> 1;
            p012 = (p01 + p12 + 1) >>> 1;
            p123 = (p12 + p23 + 1) >>> 1;
            mid  = (p012 + p123 + 1) >>> 1;
            q[k] = cur[k];
            q[2+k] = p01;
            q[4+k] = p012;
            q[6+k] = mid;
            held[top][k] = mid;
            held[top][2+k] = p123;
            held[top][4+k] = p23;
            held[top][6+k] = cur[6+k];
          end
          held_lvl[top] = level + 1;
          top++;
          cur = q;
          level++;
        end
      end
    endfunction

    task automatic check_vertex(vertex_t got);
      vertex_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected vertex (%0d,%0d)", got.x, got.y));
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x)
        report($sformatf("point_x %0d, expected %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("point_y %0d, expected %0d", got.y, want.y));
      if (got.last !== want.last)
        report($sformatf("last_point %0b, expected %0b", got.last, want.last));
      if (got.capped !== want.capped)
        report($sformatf("depth_capped %0b, expected %0b", got.capped, want.capped));
    endtask
  endclass

  vertex_board board = new();

  // Clock and cycle limit.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL cubic_bezier_adaptive_flattener");
      $finish;
    end
  end

  // Receiver: random stall bursts, none in the quiet part of the run.
  initial begin
    int n;
    point_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      point_ch.ready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        point_ch.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Each accepted vertex transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    vertex_t got;
    if (rst_ni && point_ch.valid && point_ch.ready) begin
      got.x = point_ch.point_x;
      got.y = point_ch.point_y;
      got.last = point_ch.last_point;
      got.capped = point_ch.depth_capped;
      vertices_seen++;
      if (got.capped === 1'b1) capped_seen++;
      board.check_vertex(got);
    end
  end

  // Sends one curve, at times after a random idle burst, and predicts it on acceptance.
  task automatic send_curve(curve_t c);
    int n;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      curve_ch.valid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(posedge clk_i);
    end
    curve_ch.valid   <= 1'b1;
    curve_ch.start_x <= c.sx;
    curve_ch.start_y <= c.sy;
    curve_ch.ctrl1_x <= c.c1x;
    curve_ch.ctrl1_y <= c.c1y;
    curve_ch.ctrl2_x <= c.c2x;
    curve_ch.ctrl2_y <= c.c2y;
    curve_ch.end_x   <= c.ex;
    curve_ch.end_y   <= c.ey;
    @(posedge clk_i);
    while (!curve_ch.ready) @(posedge clk_i);
    board.note_curve(c);
    curves_sent++;
  endtask

  // Waits until every predicted vertex has arrived and the engine has settled.
  task automatic drain();
    curve_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Tolerance writes happen only after a drain.
  task automatic write_tol(bzf_pkg::tol_t v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.tol = v;
  endtask

  function automatic curve_t make_curve(int sx, int sy, int ax, int ay,
                                        int bx, int by, int ex, int ey);
    curve_t c;
    c.sx = bzf_pkg::coord_t'(sx);  c.sy = bzf_pkg::coord_t'(sy);
    c.c1x = bzf_pkg::coord_t'(ax); c.c1y = bzf_pkg::coord_t'(ay);
    c.c2x = bzf_pkg::coord_t'(bx); c.c2y = bzf_pkg::coord_t'(by);
    c.ex = bzf_pkg::coord_t'(ex);  c.ey = bzf_pkg::coord_t'(ey);
    return c;
  endfunction

  // Mostly small curves around a random center; some span the full range.
  function automatic curve_t random_curve();
    curve_t c;
    int base_x, base_y, span;
    if ($urandom_range(0, 9) < 2) begin
      c.sx = bzf_pkg::coord_t'($urandom);  c.sy = bzf_pkg::coord_t'($urandom);
      c.c1x = bzf_pkg::coord_t'($urandom); c.c1y = bzf_pkg::coord_t'($urandom);
      c.c2x = bzf_pkg::coord_t'($urandom); c.c2y = bzf_pkg::coord_t'($urandom);
      c.ex = bzf_pkg::coord_t'($urandom);  c.ey = bzf_pkg::coord_t'($urandom);
    end else begin
      base_x = $urandom_range(0, 8000000) - 4000000;
      base_y = $urandom_range(0, 8000000) - 4000000;
      span = 1 << $urandom_range(2, 14);
      c.sx = bzf_pkg::coord_t'(base_x + $urandom_range(0, span) - span / 2);
      c.sy = bzf_pkg::coord_t'(base_y + $urandom_range(0, span) - span / 2);
      c.c1x = bzf_pkg::coord_t'(base_x + $urandom_range(0, span) - span / 2);
      c.c1y = bzf_pkg::coord_t'(base_y + $urandom_range(0, span) - span / 2);
      c.c2x = bzf_pkg::coord_t'(base_x + $urandom_range(0, span) - span / 2);
      c.c2y = bzf_pkg::coord_t'(base_y + $urandom_range(0, span) - span / 2);
      c.ex = bzf_pkg::coord_t'(base_x + $urandom_range(0, span) - span / 2);
      c.ey = bzf_pkg::coord_t'(base_y + $urandom_range(0, span) - span / 2);
    end
    return c;
  endfunction

  // Main sequence: directed curves, then random phases under several tolerances.
  initial begin
    bzf_pkg::tol_t tols[5];
    int ph, i;
    quiet = 1'b0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    curve_ch.valid <= 1'b0;
    curve_ch.start_x <= '0; curve_ch.start_y <= '0;
    curve_ch.ctrl1_x <= '0; curve_ch.ctrl1_y <= '0;
    curve_ch.ctrl2_x <= '0; curve_ch.ctrl2_y <= '0;
    curve_ch.end_x   <= '0; curve_ch.end_y   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed curves at the reset tolerance.
    send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
    send_curve(make_curve(100, 200, 100, 200, 100, 200, 100, 200));
    send_curve(make_curve(0, 0, 5000, 9000, -7000, 300, 0, 0));
    send_curve(make_curve(0, 0, 256, 256, 512, 512, 768, 768));
    send_curve(make_curve(-8388608, -8388608, -8388608, -8388608,
                          8388607, 8388607, 8388607, 8388607));
    send_curve(make_curve(-8388608, 8388607, 8388607, 8388607,
                          -8388608, -8388608, 8388607, -8388608));
    send_curve(make_curve(8388607, 0, -8388608, 0, 8388607, 0, -8388608, 0));
    send_curve(make_curve(0, 0, 1000, 2000, 3000, 2000, 4000, 0));
    send_curve(make_curve(0, 0, 4000, 4000, 0, 4000, 4000, 0));
    send_curve(make_curve(-1, -1, 1, -1, -1, 1, 1, 1));
    send_curve(make_curve(0, 0, 3, 1, 5, 1, 8, 0));
    send_curve(make_curve(-300, 50, 700, -900, 1200, 1800, -40, 20));
    send_curve(make_curve(10, 10, 10, 10, 2000, 2000, 2000, 2000));
    drain();

    // Zero tolerance: collinear pieces stay flat, the rest hit the depth limit.
    write_tol('0);
    send_curve(make_curve(0, 0, 256, 0, 512, 0, 1024, 0));
    send_curve(make_curve(0, 0, 100, 300, 200, -300, 300, 0));
    send_curve(make_curve(5, 5, 5, 5, 5, 5, 5, 5));
    send_curve(make_curve(-8388608, 8388607, 0, 0, 0, 0, 8388607, -8388608));

    // Widest tolerance: nearly everything is flat at once.
    write_tol(16'hFFFF);
    send_curve(make_curve(-8388608, -8388608, 8388607, -8388608,
                          -8388608, 8388607, 8388607, 8388607));
    for (i = 0; i < 8; i++) send_curve(random_curve());

    // Random phases; the sender also pauses for a full drain now and then.
    tols[0] = 16'd1;
    tols[1] = bzf_pkg::tol_t'($urandom);
    tols[2] = 16'd300;
    tols[3] = bzf_pkg::tol_t'($urandom_range(16, 2000));
    tols[4] = bzf_pkg::TolReset;
    for (ph = 0; ph < 5; ph++) begin
      write_tol(tols[ph]);
      if (ph == 4) quiet = 1'b1;
      for (i = 0; i < 47; i++) begin
        if (i == 20) drain();
        send_curve(random_curve());
      end
    end

    drain();
    $display("Covered %0d curves giving %0d vertices, %0d of them depth capped,",
             curves_sent, vertices_seen, capped_seen);
    $display("under tolerances from zero to full scale with random stalls on both sides.");
    if (errors == 0) begin
      $display("PASS cubic_bezier_adaptive_flattener");
    end else begin
      $display("FAIL cubic_bezier_adaptive_flattener");
    end
    $finish;
  end

endmodule
